[rtl/triangle_circumcenter_assert.svh]
// ----------------------------------------------------------------------------
// triangle circumcenter assertion macros
// immediate-consequence and next-cycle checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`define TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define TCC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCC_ASSERT_IMP(label, ante, cons, msg)
`define TCC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// widths and stage types shared by the circumcenter pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tcc_pkg;
	localparam int CW   = 32;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int LW   = DW;
	localparam int HW   = PW - LW;
	localparam int PPW  = DW + LW + 1;
	localparam int DSW  = PW + 2;
	localparam int MW   = DW + PW;
	localparam int NW   = MW + 1;
	localparam int NMW  = NW - 1;
	localparam int DMW  = PW + 1;
	localparam int LMW  = NMW + 2;
	localparam int QB   = CW;
	localparam int SQW  = 2 * CW + 2;
	localparam int RTW  = SQW / 2;
	localparam int SRW  = RTW + 3;

	localparam logic [CW-1:0] SMAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] SMIN = {1'b1, {(CW - 1){1'b0}}};

	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] bx;
		logic [CW-1:0] by;
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
	} vtx_t;

	typedef struct packed {
		logic [NMW-1:0] nx_mag;
		logic [NMW-1:0] ny_mag;
		logic           x_neg;
		logic           y_neg;
		logic [DMW-1:0] d_mag;
		logic           degen;
		logic [CW-1:0]  ax;
		logic [CW-1:0]  ay;
	} front_t;

	typedef struct packed {
		logic [DMW-1:0] rem;
		logic [QB-1:0]  nlo;
		logic [QB-1:0]  q;
		logic           ovf;
		logic           neg;
	} lane_t;

	typedef struct packed {
		lane_t          x;
		lane_t          y;
		logic [DMW-1:0] d;
		logic           degen;
		logic [CW-1:0]  ax;
		logic [CW-1:0]  ay;
	} dstage_t;

	typedef struct packed {
		logic [QB:0]   qx;
		logic [QB:0]   qy;
		logic          x_neg;
		logic          y_neg;
		logic          ovx;
		logic          ovy;
		logic          degen;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
	} quot_t;

	typedef struct packed {
		logic [CW-1:0] center_x;
		logic [CW-1:0] center_y;
		logic          ovf_c;
		logic          rad_ovf;
		logic          degen;
	} bside_t;

	typedef struct packed {
		bside_t        side;
		logic [CW-1:0] qx;
		logic [CW-1:0] qy;
	} ctr_t;

	typedef struct packed {
		bside_t          side;
		logic [2*CW-1:0] x2;
		logic [2*CW-1:0] y2;
	} sqr_t;

	typedef struct packed {
		bside_t         side;
		logic [SQW-1:0] rad;
		logic [SRW-1:0] rem;
		logic [RTW-1:0] root;
	} sqst_t;

	typedef struct packed {
		logic [CW-1:0] center_x;
		logic [CW-1:0] center_y;
		logic [CW-1:0] radius;
		logic          degenerate;
		logic          overflow;
	} result_t;
endpackage

[rtl/tcc_if.sv]
// ----------------------------------------------------------------------------
// tcc channel interfaces
// triangle request channel and result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tcc_vtx_if;
	logic                          valid;
	logic                          ready;
	logic signed [tcc_pkg::CW-1:0] vertex_a_x;
	logic signed [tcc_pkg::CW-1:0] vertex_a_y;
	logic signed [tcc_pkg::CW-1:0] vertex_b_x;
	logic signed [tcc_pkg::CW-1:0] vertex_b_y;
	logic signed [tcc_pkg::CW-1:0] vertex_c_x;
	logic signed [tcc_pkg::CW-1:0] vertex_c_y;
	modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, output ready);
endinterface

interface tcc_res_if;
	logic                          valid;
	logic                          ready;
	logic signed [tcc_pkg::CW-1:0] center_x;
	logic signed [tcc_pkg::CW-1:0] center_y;
	logic [tcc_pkg::CW-1:0]        radius;
	logic                          degenerate;
	logic                          overflow;
	modport source (output valid, center_x, center_y, radius, degenerate, overflow,
		input ready);
	modport sink (input valid, center_x, center_y, radius, degenerate, overflow,
		output ready);
endinterface

[rtl/triangle_circumcenter.sv]
// ----------------------------------------------------------------------------
// triangle_circumcenter
// circumcenter and circumradius of a triangle in signed Q16.16
//
//   channel    role    payload
//   vertices   sink    vertex_a_x/y, vertex_b_x/y, vertex_c_x/y
//   result     source  center_x, center_y, radius, degenerate, overflow
//
// one triangle per cycle unless a stalled result has filled the pipe
// pipeline: 7 determinant stages, 35 divider stages, 37 center/square root stages
// reset clears the stage valid bits only, no clearing pass
// a stalled result holds the pipe back only as far as it is full, bubbles close up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_circumcenter (
	input logic       clk,
	input logic       arst_n,
	tcc_vtx_if.sink   vertices,
	tcc_res_if.source result
);
	tcc_pkg::vtx_t    vin;
	tcc_pkg::front_t  f_data;
	tcc_pkg::quot_t   q_data;
	tcc_pkg::result_t r_data;
	logic             f_valid, f_ready, q_valid, q_ready;

	assign vin = '{ax: vertices.vertex_a_x, ay: vertices.vertex_a_y,
		bx: vertices.vertex_b_x, by: vertices.vertex_b_y,
		cx: vertices.vertex_c_x, cy: vertices.vertex_c_y};

	tcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vertices.valid),
		.up_ready (vertices.ready),
		.up_data  (vin),
		.dn_valid (f_valid),
		.dn_ready (f_ready),
		.dn_data  (f_data)
	);

	tcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (f_valid),
		.up_ready (f_ready),
		.up_data  (f_data),
		.dn_valid (q_valid),
		.dn_ready (q_ready),
		.dn_data  (q_data)
	);

	tcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (q_valid),
		.up_ready (q_ready),
		.up_data  (q_data),
		.dn_valid (result.valid),
		.dn_ready (result.ready),
		.dn_data  (r_data)
	);

	assign result.center_x   = r_data.center_x;
	assign result.center_y   = r_data.center_y;
	assign result.radius     = r_data.radius;
	assign result.degenerate = r_data.degenerate;
	assign result.overflow   = r_data.overflow;
endmodule

[rtl/tcc_front.sv]
// ----------------------------------------------------------------------------
// tcc_front
// edge vectors, determinant and bisector numerators as sign and magnitude
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  tcc_pkg::vtx_t   up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output tcc_pkg::front_t dn_data
);
	localparam int NS = 7;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	logic signed [tcc_pkg::DW-1:0]  bx_s1, by_s1, cx_s1, cy_s1;
	logic [tcc_pkg::CW-1:0]         ax_s1, ay_s1;
	logic signed [tcc_pkg::PW-1:0]  bxx_s2, byy_s2, cxx_s2, cyy_s2, bxcy_s2, bycx_s2;
	logic signed [tcc_pkg::DW-1:0]  bx_s2, by_s2, cx_s2, cy_s2;
	logic [tcc_pkg::CW-1:0]         ax_s2, ay_s2;
	logic [tcc_pkg::PW-1:0]         sb_s3, sc_s3;
	logic signed [tcc_pkg::DSW-1:0] d_s3;
	logic signed [tcc_pkg::DW-1:0]  bx_s3, by_s3, cx_s3, cy_s3;
	logic [tcc_pkg::CW-1:0]         ax_s3, ay_s3;
	logic signed [tcc_pkg::PPW-1:0] cysb_lo_s4, cysb_hi_s4, bysc_lo_s4, bysc_hi_s4;
	logic signed [tcc_pkg::PPW-1:0] bxsc_lo_s4, bxsc_hi_s4, cxsb_lo_s4, cxsb_hi_s4;
	logic signed [tcc_pkg::DSW-1:0] d_s4;
	logic [tcc_pkg::CW-1:0]         ax_s4, ay_s4;
	logic signed [tcc_pkg::MW-1:0]  cysb_s5, bysc_s5, bxsc_s5, cxsb_s5;
	logic signed [tcc_pkg::DSW-1:0] d_s5;
	logic [tcc_pkg::CW-1:0]         ax_s5, ay_s5;
	logic signed [tcc_pkg::NW-1:0]  nx_s6, ny_s6;
	logic signed [tcc_pkg::DSW-1:0] d_s6;
	logic [tcc_pkg::CW-1:0]         ax_s6, ay_s6;
	tcc_pkg::front_t                out_s7;

	logic [tcc_pkg::NW-1:0]  nx_abs, ny_abs;
	logic [tcc_pkg::DSW-1:0] d_abs;

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = dn_ready | ~(&v_q[NS-1:k]);
	end

	assign up_ready = en[0];
	assign dn_valid = v_q[NS-1];
	assign dn_data  = out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (v_q & ~en) | ({v_q[NS-2:0], up_valid} & en);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			bx_s1 <= $signed({up_data.bx[tcc_pkg::CW-1], up_data.bx})
				- $signed({up_data.ax[tcc_pkg::CW-1], up_data.ax});
			by_s1 <= $signed({up_data.by[tcc_pkg::CW-1], up_data.by})
				- $signed({up_data.ay[tcc_pkg::CW-1], up_data.ay});
			cx_s1 <= $signed({up_data.cx[tcc_pkg::CW-1], up_data.cx})
				- $signed({up_data.ax[tcc_pkg::CW-1], up_data.ax});
			cy_s1 <= $signed({up_data.cy[tcc_pkg::CW-1], up_data.cy})
				- $signed({up_data.ay[tcc_pkg::CW-1], up_data.ay});
			ax_s1 <= up_data.ax;
			ay_s1 <= up_data.ay;
		end
		if (en[1]) begin
			bxx_s2  <= bx_s1 * bx_s1;
			byy_s2  <= by_s1 * by_s1;
			cxx_s2  <= cx_s1 * cx_s1;
			cyy_s2  <= cy_s1 * cy_s1;
			bxcy_s2 <= bx_s1 * cy_s1;
			bycx_s2 <= by_s1 * cx_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
		if (en[2]) begin
			sb_s3 <= $unsigned(bxx_s2) + $unsigned(byy_s2);
			sc_s3 <= $unsigned(cxx_s2) + $unsigned(cyy_s2);
			d_s3  <= ({{2{bxcy_s2[tcc_pkg::PW-1]}}, bxcy_s2}
				- {{2{bycx_s2[tcc_pkg::PW-1]}}, bycx_s2}) << 1;
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
		end
		if (en[3]) begin
			cysb_lo_s4 <= cy_s3 * $signed({1'b0, sb_s3[tcc_pkg::LW-1:0]});
			cysb_hi_s4 <= cy_s3 * $signed({1'b0, sb_s3[tcc_pkg::PW-1:tcc_pkg::LW]});
			bysc_lo_s4 <= by_s3 * $signed({1'b0, sc_s3[tcc_pkg::LW-1:0]});
			bysc_hi_s4 <= by_s3 * $signed({1'b0, sc_s3[tcc_pkg::PW-1:tcc_pkg::LW]});
			bxsc_lo_s4 <= bx_s3 * $signed({1'b0, sc_s3[tcc_pkg::LW-1:0]});
			bxsc_hi_s4 <= bx_s3 * $signed({1'b0, sc_s3[tcc_pkg::PW-1:tcc_pkg::LW]});
			cxsb_lo_s4 <= cx_s3 * $signed({1'b0, sb_s3[tcc_pkg::LW-1:0]});
			cxsb_hi_s4 <= cx_s3 * $signed({1'b0, sb_s3[tcc_pkg::PW-1:tcc_pkg::LW]});
			d_s4       <= d_s3;
			ax_s4      <= ax_s3;
			ay_s4      <= ay_s3;
		end
		if (en[4]) begin
			cysb_s5 <= (tcc_pkg::MW'(cysb_hi_s4) <<< tcc_pkg::LW) + tcc_pkg::MW'(cysb_lo_s4);
			bysc_s5 <= (tcc_pkg::MW'(bysc_hi_s4) <<< tcc_pkg::LW) + tcc_pkg::MW'(bysc_lo_s4);
			bxsc_s5 <= (tcc_pkg::MW'(bxsc_hi_s4) <<< tcc_pkg::LW) + tcc_pkg::MW'(bxsc_lo_s4);
			cxsb_s5 <= (tcc_pkg::MW'(cxsb_hi_s4) <<< tcc_pkg::LW) + tcc_pkg::MW'(cxsb_lo_s4);
			d_s5    <= d_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
		end
		if (en[5]) begin
			nx_s6 <= tcc_pkg::NW'(cysb_s5) - tcc_pkg::NW'(bysc_s5);
			ny_s6 <= tcc_pkg::NW'(bxsc_s5) - tcc_pkg::NW'(cxsb_s5);
			d_s6  <= d_s5;
			ax_s6 <= ax_s5;
			ay_s6 <= ay_s5;
		end
		if (en[6]) begin
			out_s7.nx_mag <= nx_abs[tcc_pkg::NMW-1:0];
			out_s7.ny_mag <= ny_abs[tcc_pkg::NMW-1:0];
			out_s7.x_neg  <= nx_s6[tcc_pkg::NW-1] ^ d_s6[tcc_pkg::DSW-1];
			out_s7.y_neg  <= ny_s6[tcc_pkg::NW-1] ^ d_s6[tcc_pkg::DSW-1];
			out_s7.d_mag  <= d_abs[tcc_pkg::DMW-1:0];
			out_s7.degen  <= (d_s6 == '0);
			out_s7.ax     <= ax_s6;
			out_s7.ay     <= ay_s6;
		end
	end

	always_comb begin
		nx_abs = nx_s6[tcc_pkg::NW-1] ? $unsigned(-nx_s6) : $unsigned(nx_s6);
		ny_abs = ny_s6[tcc_pkg::NW-1] ? $unsigned(-ny_s6) : $unsigned(ny_s6);
		d_abs  = d_s6[tcc_pkg::DSW-1] ? $unsigned(-d_s6) : $unsigned(d_s6);
	end
endmodule

[rtl/tcc_div.sv]
// ----------------------------------------------------------------------------
// tcc_div
// two-lane pipelined restoring divider, one quotient bit per stage,
// range check up front and round to nearest at the end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  tcc_pkg::front_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output tcc_pkg::quot_t  dn_data
);
	localparam int NS = tcc_pkg::QB + 3;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	tcc_pkg::front_t        f_s0;
	logic [tcc_pkg::LMW-1:0] dlim_s0;
	tcc_pkg::dstage_t       div_s [1:tcc_pkg::QB+1];
	tcc_pkg::quot_t         rnd_s;

	function automatic tcc_pkg::lane_t lane_init(input logic [tcc_pkg::NMW-1:0] n,
		input logic neg, input logic [tcc_pkg::LMW-1:0] lim);
		tcc_pkg::lane_t l;
		l.rem = n[tcc_pkg::NMW-1:tcc_pkg::QB];
		l.nlo = n[tcc_pkg::QB-1:0];
		l.q   = '0;
		l.ovf = (tcc_pkg::LMW'({n, 1'b0}) >= lim);
		l.neg = neg;
		return l;
	endfunction

	function automatic tcc_pkg::lane_t lane_step(input tcc_pkg::lane_t l,
		input logic [tcc_pkg::DMW-1:0] d);
		tcc_pkg::lane_t     o;
		logic [tcc_pkg::DMW:0] r2;
		logic [tcc_pkg::DMW:0] dif;
		o     = l;
		r2    = {l.rem, l.nlo[tcc_pkg::QB-1]};
		dif   = r2 - {1'b0, d};
		o.nlo = {l.nlo[tcc_pkg::QB-2:0], 1'b0};
		if (!dif[tcc_pkg::DMW]) begin
			o.rem = dif[tcc_pkg::DMW-1:0];
			o.q   = {l.q[tcc_pkg::QB-2:0], 1'b1};
		end else begin
			o.rem = r2[tcc_pkg::DMW-1:0];
			o.q   = {l.q[tcc_pkg::QB-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [tcc_pkg::QB:0] lane_round(input tcc_pkg::lane_t l,
		input logic [tcc_pkg::DMW-1:0] d);
		logic up;
		up = ({l.rem, 1'b0} >= {1'b0, d});
		return {1'b0, l.q} + {{tcc_pkg::QB{1'b0}}, up};
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = dn_ready | ~(&v_q[NS-1:k]);
	end

	assign up_ready = en[0];
	assign dn_valid = v_q[NS-1];
	assign dn_data  = rnd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (v_q & ~en) | ({v_q[NS-2:0], up_valid} & en);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			f_s0    <= up_data;
			dlim_s0 <= (tcc_pkg::LMW'(up_data.d_mag) << (tcc_pkg::QB + 1))
				- tcc_pkg::LMW'(up_data.d_mag);
		end
		if (en[1]) begin
			div_s[1].x     <= lane_init(f_s0.nx_mag, f_s0.x_neg, dlim_s0);
			div_s[1].y     <= lane_init(f_s0.ny_mag, f_s0.y_neg, dlim_s0);
			div_s[1].d     <= f_s0.d_mag;
			div_s[1].degen <= f_s0.degen;
			div_s[1].ax    <= f_s0.ax;
			div_s[1].ay    <= f_s0.ay;
		end
	end

	for (genvar k = 2; k <= tcc_pkg::QB + 1; k++) begin : g_bit
		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k].x     <= lane_step(div_s[k-1].x, div_s[k-1].d);
				div_s[k].y     <= lane_step(div_s[k-1].y, div_s[k-1].d);
				div_s[k].d     <= div_s[k-1].d;
				div_s[k].degen <= div_s[k-1].degen;
				div_s[k].ax    <= div_s[k-1].ax;
				div_s[k].ay    <= div_s[k-1].ay;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			rnd_s.qx    <= lane_round(div_s[tcc_pkg::QB+1].x, div_s[tcc_pkg::QB+1].d);
			rnd_s.qy    <= lane_round(div_s[tcc_pkg::QB+1].y, div_s[tcc_pkg::QB+1].d);
			rnd_s.x_neg <= div_s[tcc_pkg::QB+1].x.neg;
			rnd_s.y_neg <= div_s[tcc_pkg::QB+1].y.neg;
			rnd_s.ovx   <= div_s[tcc_pkg::QB+1].x.ovf;
			rnd_s.ovy   <= div_s[tcc_pkg::QB+1].y.ovf;
			rnd_s.degen <= div_s[tcc_pkg::QB+1].degen;
			rnd_s.ax    <= div_s[tcc_pkg::QB+1].ax;
			rnd_s.ay    <= div_s[tcc_pkg::QB+1].ay;
		end
	end
endmodule

[rtl/tcc_back.sv]
// ----------------------------------------------------------------------------
// tcc_back
// center offset and clamp, squared offsets, pipelined integer square root
// with round to nearest, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_circumcenter_assert.svh"
module tcc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  tcc_pkg::quot_t   up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output tcc_pkg::result_t dn_data
);
	localparam int NS = tcc_pkg::RTW + 4;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	tcc_pkg::ctr_t    c_s1;
	tcc_pkg::sqr_t    sq_s2;
	tcc_pkg::sqst_t   sqr_s [2:tcc_pkg::RTW+2];
	tcc_pkg::result_t out_s;

	logic [tcc_pkg::CW:0]  cxo, cyo;
	logic [tcc_pkg::RTW:0] res;
	logic                  big;
	tcc_pkg::sqst_t        last;

	function automatic logic [tcc_pkg::CW:0] center_sat(input logic [tcc_pkg::CW-1:0] base,
		input logic [tcc_pkg::QB:0] q, input logic neg, input logic ov);
		logic [tcc_pkg::CW+2:0] off;
		logic [tcc_pkg::CW+2:0] sum;
		logic [tcc_pkg::CW-1:0] v;
		logic                   o;
		off = {2'b00, q};
		if (neg) begin
			off = -off;
		end
		sum = {{3{base[tcc_pkg::CW-1]}}, base} + off;
		if (ov) begin
			o = 1'b1;
			v = neg ? tcc_pkg::SMIN : tcc_pkg::SMAX;
		end else if (sum[tcc_pkg::CW+2:tcc_pkg::CW-1] != '0
			&& sum[tcc_pkg::CW+2:tcc_pkg::CW-1] != '1) begin
			o = 1'b1;
			v = sum[tcc_pkg::CW+2] ? tcc_pkg::SMIN : tcc_pkg::SMAX;
		end else begin
			o = 1'b0;
			v = sum[tcc_pkg::CW-1:0];
		end
		return {o, v};
	endfunction

	function automatic tcc_pkg::sqst_t sqrt_step(input tcc_pkg::sqst_t s);
		tcc_pkg::sqst_t       o;
		logic [tcc_pkg::SRW-1:0] r;
		logic [tcc_pkg::SRW-1:0] trial;
		o     = s;
		r     = {s.rem[tcc_pkg::SRW-3:0], s.rad[tcc_pkg::SQW-1:tcc_pkg::SQW-2]};
		trial = tcc_pkg::SRW'({s.root, 2'b01});
		o.rad = {s.rad[tcc_pkg::SQW-3:0], 2'b00};
		if (r >= trial) begin
			o.rem  = r - trial;
			o.root = {s.root[tcc_pkg::RTW-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[tcc_pkg::RTW-2:0], 1'b0};
		end
		return o;
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = dn_ready | ~(&v_q[NS-1:k]);
	end

	assign up_ready = en[0];
	assign dn_valid = v_q[NS-1];
	assign dn_data  = out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (v_q & ~en) | ({v_q[NS-2:0], up_valid} & en);
		end
	end

	always_comb begin
		cxo  = center_sat(up_data.ax, up_data.qx, up_data.x_neg, up_data.ovx);
		cyo  = center_sat(up_data.ay, up_data.qy, up_data.y_neg, up_data.ovy);
		last = sqr_s[tcc_pkg::RTW+2];
		res  = {1'b0, last.root}
			+ {{tcc_pkg::RTW{1'b0}}, (last.rem > tcc_pkg::SRW'(last.root))};
		big  = |res[tcc_pkg::RTW:tcc_pkg::CW];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s1.side.center_x <= cxo[tcc_pkg::CW-1:0];
			c_s1.side.center_y <= cyo[tcc_pkg::CW-1:0];
			c_s1.side.ovf_c    <= cxo[tcc_pkg::CW] | cyo[tcc_pkg::CW];
			c_s1.side.rad_ovf  <= up_data.ovx | up_data.ovy;
			c_s1.side.degen    <= up_data.degen;
			c_s1.qx            <= up_data.qx[tcc_pkg::CW-1:0];
			c_s1.qy            <= up_data.qy[tcc_pkg::CW-1:0];
		end
		if (en[1]) begin
			sq_s2.side <= c_s1.side;
			sq_s2.x2   <= c_s1.qx * c_s1.qx;
			sq_s2.y2   <= c_s1.qy * c_s1.qy;
		end
		if (en[2]) begin
			sqr_s[2].side <= sq_s2.side;
			sqr_s[2].rad  <= tcc_pkg::SQW'(sq_s2.x2) + tcc_pkg::SQW'(sq_s2.y2);
			sqr_s[2].rem  <= '0;
			sqr_s[2].root <= '0;
		end
	end

	for (genvar k = 3; k <= tcc_pkg::RTW + 2; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sqr_s[k] <= sqrt_step(sqr_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			if (last.side.degen) begin
				out_s <= '{center_x: '0, center_y: '0, radius: '0,
					degenerate: 1'b1, overflow: 1'b0};
			end else begin
				out_s.center_x   <= last.side.center_x;
				out_s.center_y   <= last.side.center_y;
				out_s.radius     <= (last.side.rad_ovf || big) ? '1
					: res[tcc_pkg::CW-1:0];
				out_s.degenerate <= 1'b0;
				out_s.overflow   <= last.side.ovf_c | last.side.rad_ovf | big;
			end
		end
	end

	`TCC_ASSERT_IMP(a_degen_clean, v_q[NS-1] && out_s.degenerate, out_s.center_x == '0 && out_s.center_y == '0 && out_s.radius == '0 && !out_s.overflow, "degenerate result carries data")
	`TCC_ASSERT_IMP(a_block_only_full, !en[0], (&v_q) && !dn_ready, "request blocked with a bubble inside")
	`TCC_ASSERT_NXT(a_stall_keeps, v_q[NS-1] && v_q[NS-2] && !dn_ready, v_q[NS-1] && v_q[NS-2], "stalled result dropped")
endmodule
